[rtl/core/thermistor_adc_to_celsius_macros.svh]
// assertion helpers used by the checker of this block
`ifndef THERMISTOR_ADC_TO_CELSIUS_MACROS_SVH
`define THERMISTOR_ADC_TO_CELSIUS_MACROS_SVH

// same-cycle implication, sampled on the block clock, off while in reset
`define TAC_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("thermistor_adc_to_celsius check failed");

// next-cycle implication
`define TAC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("thermistor_adc_to_celsius check failed");

`endif

[rtl/core/tac_pkg.sv]
`timescale 1ns / 1ps

package tac_pkg;

  localparam int unsigned SERIES_W   = 20;
  localparam int unsigned SUPPLY_W   = 16;
  localparam int unsigned OFFSET_W   = 8;
  localparam int unsigned TEMP_W     = 10;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned LN_FRAC    = 24;
  localparam int unsigned SQ_FRAC    = 30;
  localparam int unsigned SQ_STEPS   = LN_FRAC;
  localparam int unsigned COEF_MAX_W = 48;
  localparam int unsigned COEF_SPLIT = 24;
  localparam int unsigned LN2_W      = 32;

  localparam logic [LN2_W-1:0]    LN2_Q32    = 32'd2977044472;
  localparam logic [SERIES_W-1:0] SERIES_RST = 20'd1000;
  localparam logic [SUPPLY_W-1:0] SUPPLY_RST = 16'd3300;
  localparam logic [63:0]         COEF_A_RST = 64'd23089744183;
  localparam logic [63:0]         COEF_B_RST = 64'd877300329;
  localparam logic [63:0]         COEF_C_RST = 64'd7146826;
  localparam logic [OFFSET_W-1:0] OFFSET_RST = 8'd5;
  localparam logic [TEMP_W-1:0]   TEMP_MAX   = 10'd511;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SERIES = 3'd0,
    CFG_SUPPLY = 3'd1,
    CFG_COEF_A = 3'd2,
    CFG_COEF_B = 3'd3,
    CFG_COEF_C = 3'd4,
    CFG_OFFSET = 3'd5
  } tac_cfg_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ZERO_RES = 2'd1,
    ST_SUPPLY   = 2'd2
  } tac_status_e;

  // per-word flags that ride along the pipeline
  typedef struct packed {
    tac_status_e status;
    logic        dzero;
  } tac_tag_t;

endpackage

[rtl/core/tac_udiv.sv]
`timescale 1ns / 1ps

module tac_udiv import tac_pkg::*; #(
  parameter int unsigned NUM_W = 32,
  parameter int unsigned DEN_W = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,
  input  logic             valid_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  input  tac_tag_t         tag_i,
  output logic             valid_o,
  output logic [NUM_W-1:0] quo_o,
  output logic [DEN_W-1:0] rem_o,
  output tac_tag_t         tag_o
);

  logic             v_q   [NUM_W];
  logic [DEN_W-1:0] rem_q [NUM_W];
  logic [DEN_W-1:0] den_q [NUM_W];
  logic [NUM_W-1:0] num_q [NUM_W];
  logic [NUM_W-1:0] quo_q [NUM_W];
  tac_tag_t         tag_q [NUM_W];

  // restoring division, one quotient bit per stage, msb first
  for (genvar s = 0; s < NUM_W; s++) begin : g_step
    logic             v_in;
    logic [DEN_W-1:0] rem_in;
    logic [DEN_W-1:0] den_in;
    logic [NUM_W-1:0] num_in;
    logic [NUM_W-1:0] quo_in;
    tac_tag_t         tag_in;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;

    if (s == 0) begin : g_head
      assign v_in   = valid_i;
      assign rem_in = '0;
      assign den_in = den_i;
      assign num_in = num_i;
      assign quo_in = '0;
      assign tag_in = tag_i;
    end else begin : g_body
      assign v_in   = v_q[s-1];
      assign rem_in = rem_q[s-1];
      assign den_in = den_q[s-1];
      assign num_in = num_q[s-1];
      assign quo_in = quo_q[s-1];
      assign tag_in = tag_q[s-1];
    end

    assign trial = {rem_in, num_in[NUM_W-1]};
    assign diff  = trial - {1'b0, den_in};
    assign ge    = (trial >= {1'b0, den_in});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (adv_i) begin
        v_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        rem_q[s] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        quo_q[s] <= {quo_in[NUM_W-2:0], ge};
        num_q[s] <= num_in << 1;
        den_q[s] <= den_in;
        tag_q[s] <= tag_in;
      end
    end
  end

  assign valid_o = v_q[NUM_W-1];
  assign quo_o   = quo_q[NUM_W-1];
  assign rem_o   = rem_q[NUM_W-1];
  assign tag_o   = tag_q[NUM_W-1];

endmodule

[rtl/core/tac_ln.sv]
`timescale 1ns / 1ps

module tac_ln import tac_pkg::*; #(
  parameter int unsigned R_W = 32,
  localparam int unsigned K_W = $clog2(R_W),
  localparam int unsigned LG_W = K_W + LN_FRAC
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            adv_i,
  input  logic            valid_i,
  input  logic [R_W-1:0]  r_i,
  input  tac_tag_t        tag_i,
  output logic            valid_o,
  output logic [LG_W-1:0] ln_o,
  output tac_tag_t        tag_o
);

  localparam int unsigned X_W  = SQ_FRAC + 1;
  localparam int unsigned SQ_W = 2 * X_W;
  localparam int unsigned P_W  = LG_W + LN2_W;

  // leading one
  logic [K_W-1:0] k_d;
  logic           va_q;
  logic [R_W-1:0] ra_q;
  logic [K_W-1:0] ka_q;
  tac_tag_t       taga_q;

  always_comb begin
    k_d = '0;
    for (int i = 0; i < R_W; i++) begin
      if (r_i[i]) begin
        k_d = K_W'(i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (adv_i) begin
      va_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      ra_q   <= r_i;
      ka_q   <= k_d;
      taga_q <= tag_i;
    end
  end

  // normalise mantissa into [1, 2) with 30 fraction bits
  logic [R_W+SQ_FRAC-1:0] shifted;
  logic                   vb_q;
  logic [X_W-1:0]         xb_q;
  logic [K_W-1:0]         kb_q;
  tac_tag_t               tagb_q;

  assign shifted = {ra_q, SQ_FRAC'(0)} >> ka_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
    end else if (adv_i) begin
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      xb_q   <= shifted[X_W-1:0];
      kb_q   <= ka_q;
      tagb_q <= taga_q;
    end
  end

  // one fraction bit of log2 per squaring stage
  logic               v_q   [SQ_STEPS];
  logic [X_W-1:0]     x_q   [SQ_STEPS];
  logic [LN_FRAC-1:0] f_q   [SQ_STEPS];
  logic [K_W-1:0]     k_q   [SQ_STEPS];
  tac_tag_t           tag_q [SQ_STEPS];

  for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sq
    logic               v_in;
    logic [X_W-1:0]     x_in;
    logic [LN_FRAC-1:0] f_in;
    logic [K_W-1:0]     k_in;
    tac_tag_t           tag_in;
    logic [SQ_W-1:0]    sq;
    logic [X_W:0]       y;

    if (j == 0) begin : g_head
      assign v_in   = vb_q;
      assign x_in   = xb_q;
      assign f_in   = '0;
      assign k_in   = kb_q;
      assign tag_in = tagb_q;
    end else begin : g_body
      assign v_in   = v_q[j-1];
      assign x_in   = x_q[j-1];
      assign f_in   = f_q[j-1];
      assign k_in   = k_q[j-1];
      assign tag_in = tag_q[j-1];
    end

    assign sq = SQ_W'(x_in) * SQ_W'(x_in);
    assign y  = sq[SQ_W-1:SQ_FRAC];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j] <= 1'b0;
      end else if (adv_i) begin
        v_q[j] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        x_q[j]   <= y[X_W] ? y[X_W:1] : y[X_W-1:0];
        f_q[j]   <= {f_in[LN_FRAC-2:0], y[X_W]};
        k_q[j]   <= k_in;
        tag_q[j] <= tag_in;
      end
    end
  end

  // scale log2 by ln 2
  logic [LG_W-1:0] lg2;
  logic [P_W-1:0]  prod;
  logic            vl_q;
  logic [LG_W-1:0] ln_q;
  tac_tag_t        tagl_q;

  assign lg2  = {k_q[SQ_STEPS-1], f_q[SQ_STEPS-1]};
  assign prod = P_W'(lg2) * P_W'(LN2_Q32);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vl_q <= 1'b0;
    end else if (adv_i) begin
      vl_q <= v_q[SQ_STEPS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      ln_q   <= prod[P_W-1:LN2_W];
      tagl_q <= tag_q[SQ_STEPS-1];
    end
  end

  assign valid_o = vl_q;
  assign ln_o    = ln_q;
  assign tag_o   = tagl_q;

endmodule

[rtl/core/tac_poly.sv]
`timescale 1ns / 1ps

module tac_poly import tac_pkg::*; #(
  parameter int unsigned LG_W = 30,
  parameter int unsigned CF_W = 40,
  localparam int unsigned L2_W = 2 * LG_W - LN_FRAC,
  localparam int unsigned L3_W = L2_W + LG_W - LN_FRAC,
  localparam int unsigned D_W = COEF_SPLIT + L3_W + 2
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            adv_i,
  input  logic            valid_i,
  input  logic [LG_W-1:0] ln_i,
  input  tac_tag_t        tag_i,
  input  logic [CF_W-1:0] coef_a_i,
  input  logic [CF_W-1:0] coef_b_i,
  input  logic [CF_W-1:0] coef_c_i,
  output logic            valid_o,
  output logic [D_W-1:0]  d_o,
  output tac_tag_t        tag_o
);

  localparam int unsigned H_W   = COEF_SPLIT;
  localparam int unsigned PL_W  = 2 * LG_W;
  localparam int unsigned PB_W  = H_W + LG_W;
  localparam int unsigned BT_W  = PB_W + 1;
  localparam int unsigned P3_W  = L2_W + LG_W;
  localparam int unsigned PC_W  = H_W + L3_W;

  // coefficient split: c*x >> 24 == hi*x + ((lo*x) >> 24)
  logic [COEF_MAX_W-1:0] bx, cx;
  logic [H_W-1:0]        bh, bl, ch, cl;

  assign bx = COEF_MAX_W'(coef_b_i);
  assign cx = COEF_MAX_W'(coef_c_i);
  assign bh = bx[COEF_MAX_W-1:H_W];
  assign bl = bx[H_W-1:0];
  assign ch = cx[COEF_MAX_W-1:H_W];
  assign cl = cx[H_W-1:0];

  // stage 1: l^2, b partial products
  logic [PL_W-1:0] pl;
  logic            v1_q;
  logic [LG_W-1:0] l1_q;
  logic [L2_W-1:0] l2_q;
  logic [PB_W-1:0] pbh_q, pbl_q;
  tac_tag_t        tag1_q;

  assign pl = PL_W'(ln_i) * PL_W'(ln_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (adv_i) begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      l1_q   <= ln_i;
      l2_q   <= pl[PL_W-1:LN_FRAC];
      pbh_q  <= PB_W'(bh) * PB_W'(ln_i);
      pbl_q  <= PB_W'(bl) * PB_W'(ln_i);
      tag1_q <= tag_i;
    end
  end

  // stage 2: l^3, b term
  logic [P3_W-1:0] p3;
  logic            v2_q;
  logic [L3_W-1:0] l3_q;
  logic [BT_W-1:0] bt2_q;
  tac_tag_t        tag2_q;

  assign p3 = P3_W'(l2_q) * P3_W'(l1_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (adv_i) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      l3_q   <= p3[P3_W-1:LN_FRAC];
      bt2_q  <= BT_W'(pbh_q) + BT_W'(pbl_q[PB_W-1:LN_FRAC]);
      tag2_q <= tag1_q;
    end
  end

  // stage 3: c partial products
  logic            v3_q;
  logic [PC_W-1:0] pch_q, pcl_q;
  logic [BT_W-1:0] bt3_q;
  tac_tag_t        tag3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (adv_i) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      pch_q  <= PC_W'(ch) * PC_W'(l3_q);
      pcl_q  <= PC_W'(cl) * PC_W'(l3_q);
      bt3_q  <= bt2_q;
      tag3_q <= tag2_q;
    end
  end

  // stage 4: denominator sum
  logic           v4_q;
  logic [D_W-1:0] d4_q;
  tac_tag_t       tag4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (adv_i) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      d4_q   <= D_W'(coef_a_i) + D_W'(bt3_q) + D_W'(pch_q)
              + D_W'(pcl_q[PC_W-1:LN_FRAC]);
      tag4_q <= tag3_q;
    end
  end

  assign valid_o = v4_q;
  assign d_o     = d4_q;
  assign tag_o   = tag4_q;

endmodule

[rtl/core/thermistor_adc_to_celsius.sv]
`timescale 1ns / 1ps

// Converts one thermistor divider ADC code per clock into whole degrees with status.
// The pipeline takes a new word every cycle unless the output stalls. Its depth is set
// mostly by the two bit-per-stage dividers (divider resistance, then the reciprocal)
// and the 24 squaring stages of the log; a stall at the output freezes the whole pipe
// and lowers in_ready_o. Configuration registers are indexed 0 to 5 (series resistance,
// supply code, coefficients a, b, c, offset), take effect at once and should be
// written only while no word is in flight; other indexes are ignored.
module thermistor_adc_to_celsius import tac_pkg::*; #(
  parameter int unsigned ADC_BITS       = 12,
  parameter int unsigned COEF_FRAC_BITS = 40
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [COEF_FRAC_BITS-1:0] cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [ADC_BITS-1:0]       adc_code_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic signed [TEMP_W-1:0]  temperature_o,
  output logic [1:0]                status_o
);

  localparam int unsigned CF_W = COEF_FRAC_BITS;
  localparam int unsigned R_W  = ADC_BITS + SERIES_W;
  localparam int unsigned K_W  = $clog2(R_W);
  localparam int unsigned LG_W = K_W + LN_FRAC;
  localparam int unsigned L2_W = 2 * LG_W - LN_FRAC;
  localparam int unsigned L3_W = L2_W + LG_W - LN_FRAC;
  localparam int unsigned D_W  = COEF_SPLIT + L3_W + 2;
  localparam int unsigned Q_W  = CF_W + 1;

  // configuration registers
  logic [SERIES_W-1:0] series_q;
  logic [SUPPLY_W-1:0] supply_q;
  logic [CF_W-1:0]     coef_a_q, coef_b_q, coef_c_q;
  logic [OFFSET_W-1:0] offset_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      series_q <= SERIES_RST;
      supply_q <= SUPPLY_RST;
      coef_a_q <= CF_W'(COEF_A_RST);
      coef_b_q <= CF_W'(COEF_B_RST);
      coef_c_q <= CF_W'(COEF_C_RST);
      offset_q <= OFFSET_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_SERIES: series_q <= cfg_data_i[SERIES_W-1:0];
        CFG_SUPPLY: supply_q <= cfg_data_i[SUPPLY_W-1:0];
        CFG_COEF_A: coef_a_q <= cfg_data_i;
        CFG_COEF_B: coef_b_q <= cfg_data_i;
        CFG_COEF_C: coef_c_q <= cfg_data_i;
        CFG_OFFSET: offset_q <= cfg_data_i[OFFSET_W-1:0];
        default: ;
      endcase
    end
  end

  // global advance: the output register is free or being emptied
  logic out_valid_q;
  logic adv;

  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;

  // entry: distance from supply
  logic [SUPPLY_W-1:0] code_ext, diff_d;
  tac_tag_t            tag0_d;

  assign code_ext = SUPPLY_W'(adc_code_i);

  always_comb begin
    diff_d = (supply_q >= code_ext) ? (supply_q - code_ext) : (code_ext - supply_q);
    tag0_d.status = (diff_d == '0) ? ST_SUPPLY : ST_OK;
    tag0_d.dzero  = 1'b0;
  end

  logic                v0_q;
  logic [ADC_BITS-1:0] code0_q;
  logic [SUPPLY_W-1:0] diff0_q;
  tac_tag_t            tag0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (adv) begin
      v0_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      code0_q <= adc_code_i;
      diff0_q <= diff_d;
      tag0_q  <= tag0_d;
    end
  end

  // numerator of the divider formula
  logic                v1_q;
  logic [R_W-1:0]      prod1_q;
  logic [SUPPLY_W-1:0] diff1_q;
  tac_tag_t            tag1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (adv) begin
      v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      prod1_q <= R_W'(code0_q) * R_W'(series_q);
      diff1_q <= diff0_q;
      tag1_q  <= tag0_q;
    end
  end

  // resistance
  logic                rv;
  logic [R_W-1:0]      r;
  logic [SUPPLY_W-1:0] r_rem;
  tac_tag_t            r_tag, ln_tag_in;

  tac_udiv #(
    .NUM_W (R_W),
    .DEN_W (SUPPLY_W)
  ) u_res_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (v1_q),
    .num_i   (prod1_q),
    .den_i   (diff1_q),
    .tag_i   (tag1_q),
    .valid_o (rv),
    .quo_o   (r),
    .rem_o   (r_rem),
    .tag_o   (r_tag)
  );

  always_comb begin
    ln_tag_in = r_tag;
    if (r_tag.status == ST_OK && r == '0) begin
      ln_tag_in.status = ST_ZERO_RES;
    end
  end

  // ln r
  logic            lv;
  logic [LG_W-1:0] ln_val;
  tac_tag_t        ln_tag;

  tac_ln #(
    .R_W (R_W)
  ) u_ln (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (rv),
    .r_i     (r),
    .tag_i   (ln_tag_in),
    .valid_o (lv),
    .ln_o    (ln_val),
    .tag_o   (ln_tag)
  );

  // denominator of the reciprocal
  logic           dv;
  logic [D_W-1:0] d_val;
  tac_tag_t       d_tag, rcp_tag_in;

  tac_poly #(
    .LG_W (LG_W),
    .CF_W (CF_W)
  ) u_poly (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .valid_i  (lv),
    .ln_i     (ln_val),
    .tag_i    (ln_tag),
    .coef_a_i (coef_a_q),
    .coef_b_i (coef_b_q),
    .coef_c_i (coef_c_q),
    .valid_o  (dv),
    .d_o      (d_val),
    .tag_o    (d_tag)
  );

  always_comb begin
    rcp_tag_in       = d_tag;
    rcp_tag_in.dzero = (d_val == '0);
  end

  // 1 / d
  logic           qv;
  logic [Q_W-1:0] q;
  logic [D_W-1:0] q_rem;
  tac_tag_t       q_tag;

  tac_udiv #(
    .NUM_W (Q_W),
    .DEN_W (D_W)
  ) u_rcp_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (dv),
    .num_i   (Q_W'(1) << CF_W),
    .den_i   (d_val),
    .tag_i   (rcp_tag_in),
    .valid_o (qv),
    .quo_o   (q),
    .rem_o   (q_rem),
    .tag_o   (q_tag)
  );

  // offset, truncation toward zero, saturation
  logic [Q_W-1:0]    q_off;
  logic [TEMP_W-1:0] temp_d;

  assign q_off = q - Q_W'(offset_q);

  always_comb begin
    if (q_tag.status != ST_OK) begin
      temp_d = '0;
    end else if (q_tag.dzero) begin
      temp_d = TEMP_MAX;
    end else if (q >= Q_W'(offset_q)) begin
      temp_d = (q_off > Q_W'(TEMP_MAX)) ? TEMP_MAX : q_off[TEMP_W-1:0];
    end else begin
      // negative side rounds toward zero when the division left a remainder
      temp_d = TEMP_W'(q[OFFSET_W-1:0]) + TEMP_W'(q_rem != '0) - TEMP_W'(offset_q);
    end
  end

  logic [TEMP_W-1:0] temp_q;
  tac_status_e       status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= qv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      temp_q   <= temp_d;
      status_q <= q_tag.status;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign temperature_o = signed'(temp_q);
  assign status_o      = status_q;

endmodule

[rtl/core/tac_checker.sv]
`timescale 1ns / 1ps

`include "thermistor_adc_to_celsius_macros.svh"

module tac_checker import tac_pkg::*; (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_ready_o,
  input logic                     out_valid_o,
  input logic                     out_ready_i,
  input logic signed [TEMP_W-1:0] temperature_o,
  input logic [1:0]               status_o
);

  // an error word always carries a zero temperature
  `TAC_ASSERT_SAME(a_err_temp_zero, out_valid_o && status_o != ST_OK, temperature_o == '0)

  // a held result blocks the input side
  `TAC_ASSERT_SAME(a_stall_backs_up, out_valid_o && !out_ready_i, !in_ready_o)

  // empty output stage never refuses a word
  `TAC_ASSERT_SAME(a_empty_takes, !out_valid_o, in_ready_o)

  // a held result stays put
  `TAC_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i,
                   out_valid_o && $stable(temperature_o) && $stable(status_o))

endmodule

bind thermistor_adc_to_celsius tac_checker u_tac_checker (.*);

[test/thermistor_adc_to_celsius_test.sv]
`timescale 1ns / 1ps

module thermistor_adc_to_celsius_test;
  import tac_pkg::*;

  localparam int unsigned ADC_W  = 12;
  localparam int unsigned COEF_W = 40;
  localparam int unsigned LATENCY = ADC_W + COEF_W + 55;
  localparam int unsigned N_RANDOM = 1500;
  localparam longint unsigned CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic signed [TEMP_W-1:0] temp;
    tac_status_e              status;
  } reading_t;

  typedef struct {
    logic [ADC_W-1:0] code;
    bit               known;
    reading_t         want;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [COEF_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [ADC_W-1:0] adc_code_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [TEMP_W-1:0] temperature_o;
  logic [1:0] status_o;

  thermistor_adc_to_celsius #(.ADC_BITS(ADC_W), .COEF_FRAC_BITS(COEF_W)) uut (.*);

  always #2 clk_i = ~clk_i;

  // shadow copy of the register file
  logic [SERIES_W-1:0] m_series;
  logic [SUPPLY_W-1:0] m_supply;
  logic [COEF_W-1:0]   m_a, m_b, m_c;
  logic [OFFSET_W-1:0] m_offset;

  reading_t pending_q[$];
  int errors = 0;
  int send_idle = 0;
  int recv_idle = 0;
  bit recv_hold = 1'b0;
  longint unsigned cycles = 0;

  function automatic logic [63:0] ln_q24(logic [63:0] r);
    int unsigned k;
    logic [63:0] t, x, frac, lg2;
    logic [127:0] sq;
    k = 0;
    t = r;
    frac = 0;
    while (t > 1) begin
      t = t >> 1;
      k++;
    end
    x = (k <= 30) ? (r << (30 - k)) : (r >> (k - 30));
    for (int i = 0; i < LN_FRAC; i++) begin
      sq = x * x;
      x = sq[93:30];
      frac = frac << 1;
      if (x >= (64'd2 << 30)) begin
        x = x >> 1;
        frac[0] = 1'b1;
      end
    end
    lg2 = (64'(k) << LN_FRAC) | frac;
    sq = lg2 * 128'(LN2_Q32);
    return sq[95:32];
  endfunction

  function automatic logic [63:0] scale_term(logic [63:0] c, logic [63:0] v);
    logic [127:0] p;
    p = 128'(c) * 128'(v);
    p = p >> LN_FRAC;
    return (p[127:64] != 0) ? {64{1'b1}} : p[63:0];
  endfunction

  function automatic reading_t convert_code(logic [ADC_W-1:0] code);
    logic [63:0] diff, r, l, l2, l3, d, q, rem, one;
    longint t;
    reading_t res;
    diff = (m_supply >= code) ? 64'(m_supply) - 64'(code) : 64'(code) - 64'(m_supply);
    if (diff == 0) return '{temp: '0, status: ST_SUPPLY};
    r = (64'(code) * 64'(m_series)) / diff;
    if (r == 0) return '{temp: '0, status: ST_ZERO_RES};
    l = ln_q24(r);
    l2 = (l * l) >> LN_FRAC;
    l3 = (l2 * l) >> LN_FRAC;
    d = 64'(m_a) + scale_term(64'(m_b), l) + scale_term(64'(m_c), l3);
    if (d == 0) begin
      t = 511;
    end else begin
      one = 64'd1 << COEF_W;
      q = one / d;
      rem = one % d;
      if (q >= 64'(m_offset)) t = longint'(q - 64'(m_offset));
      else t = longint'(q + 64'(rem != 0)) - longint'(m_offset);
      if (t > 511) t = 511;
      if (t < -512) t = -512;
    end
    res.temp = t[TEMP_W-1:0];
    res.status = ST_OK;
    return res;
  endfunction

  task automatic write_reg(tac_cfg_e idx, logic [COEF_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_SERIES: m_series = val[SERIES_W-1:0];
      CFG_SUPPLY: m_supply = val[SUPPLY_W-1:0];
      CFG_COEF_A: m_a = val;
      CFG_COEF_B: m_b = val;
      CFG_COEF_C: m_c = val;
      CFG_OFFSET: m_offset = val[OFFSET_W-1:0];
      default: ;
    endcase
  endtask

  task automatic drain;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
  endtask

  // valid stays high back to back; lowered only on an idle gap
  task automatic send_code(logic [ADC_W-1:0] code, bit known, reading_t want);
    while ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    adc_code_i <= code;
    do @(posedge clk_i); while (!in_ready_o);
    pending_q.push_back(known ? want : convert_code(code));
  endtask

  task automatic stop_sending;
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [ADC_W-1:0] pick_code;
    int unsigned sel;
    sel = $urandom_range(15);
    if (sel == 0) return '0;
    if (sel == 1) return '1;
    if (sel == 2 && m_supply < (1 << ADC_W)) return m_supply[ADC_W-1:0];
    return ADC_W'($urandom());
  endfunction

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    reading_t exp_r;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_q.size() == 0) begin
        $error("result word with nothing pending: temperature %0d", temperature_o);
        errors++;
      end else begin
        exp_r = pending_q.pop_front();
        if (temperature_o !== exp_r.temp) begin
          $error("temperature: expected %0d, got %0d", exp_r.temp, temperature_o);
          errors++;
        end
        if (status_o !== exp_r.status) begin
          $error("status: expected %0d, got %0d", exp_r.status, status_o);
          errors++;
        end
      end
    end
    out_ready_i <= !recv_hold && ($urandom_range(99) >= recv_idle);
  end

  row_t rows[$];

  initial begin
    m_series = SERIES_RST;
    m_supply = SUPPLY_RST;
    m_a = COEF_A_RST[COEF_W-1:0];
    m_b = COEF_B_RST[COEF_W-1:0];
    m_c = COEF_C_RST[COEF_W-1:0];
    m_offset = OFFSET_RST;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // code zero and code at supply read straight off; the rest via the predictor
    rows = '{
      '{12'd0, 1'b1, '{10'sd0, ST_ZERO_RES}},
      '{12'd3300, 1'b1, '{10'sd0, ST_SUPPLY}},
      '{12'd1, 1'b0, '{10'sd0, ST_OK}},
      '{12'd4095, 1'b0, '{10'sd0, ST_OK}},
      '{12'd1650, 1'b0, '{10'sd0, ST_OK}},
      '{12'd3299, 1'b0, '{10'sd0, ST_OK}},
      '{12'd3301, 1'b0, '{10'sd0, ST_OK}},
      '{12'd2048, 1'b0, '{10'sd0, ST_OK}},
      '{12'd2730, 1'b0, '{10'sd0, ST_OK}},
      '{12'd100, 1'b0, '{10'sd0, ST_OK}}
    };
    foreach (rows[i]) send_code(rows[i].code, rows[i].known, rows[i].want);
    stop_sending();
    drain();

    // zero denominator saturates high, huge coefficient drives temperature low
    write_reg(CFG_COEF_A, '0);
    write_reg(CFG_COEF_B, '0);
    write_reg(CFG_COEF_C, '0);
    send_code(12'd1000, 1'b1, '{10'sd511, ST_OK});
    send_code(12'd0, 1'b1, '{10'sd0, ST_ZERO_RES});
    stop_sending();
    drain();
    write_reg(CFG_SUPPLY, COEF_W'(16'd4095));
    write_reg(CFG_COEF_A, '1);
    write_reg(CFG_COEF_B, '1);
    write_reg(CFG_COEF_C, '1);
    write_reg(CFG_OFFSET, COEF_W'(8'd255));
    write_reg(CFG_SERIES, COEF_W'(20'd1));
    send_code(12'd4095, 1'b1, '{10'sd0, ST_SUPPLY});
    send_code(12'd1, 1'b1, '{10'sd0, ST_ZERO_RES});
    send_code(12'd4094, 1'b0, '{10'sd0, ST_OK});
    send_code(12'd2000, 1'b0, '{10'sd0, ST_OK});
    stop_sending();
    drain();

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          write_reg(CFG_SERIES, COEF_W'(SERIES_RST));
          write_reg(CFG_SUPPLY, COEF_W'(SUPPLY_RST));
          write_reg(CFG_COEF_A, COEF_A_RST[COEF_W-1:0]);
          write_reg(CFG_COEF_B, COEF_B_RST[COEF_W-1:0]);
          write_reg(CFG_COEF_C, COEF_C_RST[COEF_W-1:0]);
          write_reg(CFG_OFFSET, COEF_W'(OFFSET_RST));
        end
        1: begin
          write_reg(CFG_SERIES, COEF_W'(20'd1000000));
          write_reg(CFG_SUPPLY, COEF_W'(16'd65535));
          write_reg(CFG_OFFSET, COEF_W'(8'd0));
        end
        2: begin
          write_reg(CFG_SERIES, COEF_W'(20'hFFFFF));
          write_reg(CFG_SUPPLY, COEF_W'(16'd1));
          write_reg(CFG_COEF_A, COEF_W'($urandom()));
          write_reg(CFG_COEF_C, COEF_W'({$urandom(), $urandom()}));
        end
        3: begin
          write_reg(CFG_SERIES, COEF_W'($urandom_range(1, 1000000)));
          write_reg(CFG_SUPPLY, COEF_W'($urandom_range(1, 4095)));
          write_reg(CFG_COEF_A, COEF_W'({$urandom(), $urandom()}));
          write_reg(CFG_COEF_B, COEF_W'($urandom()));
          write_reg(CFG_COEF_C, COEF_W'($urandom_range(0, 1 << 20)));
          write_reg(CFG_OFFSET, COEF_W'($urandom_range(0, 255)));
        end
        4: begin
          write_reg(CFG_SERIES, COEF_W'(20'd10000));
          write_reg(CFG_SUPPLY, COEF_W'(16'd4095));
          write_reg(CFG_COEF_A, COEF_A_RST[COEF_W-1:0]);
          write_reg(CFG_COEF_B, COEF_B_RST[COEF_W-1:0]);
          write_reg(CFG_COEF_C, COEF_C_RST[COEF_W-1:0]);
          write_reg(CFG_OFFSET, COEF_W'(8'd255));
        end
        default: begin
          write_reg(CFG_SERIES, COEF_W'(20'd0));
          write_reg(CFG_OFFSET, COEF_W'(8'd40));
        end
      endcase
      if (phase < 2) begin
        send_idle = 6;
        recv_idle = 46;
      end else if (phase < 4) begin
        send_idle = 46;
        recv_idle = 6;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      for (int n = 0; n < N_RANDOM / 6; n++) begin
        if (phase == 5 && n == 100) begin
          stop_sending();
          while (pending_q.size() != 0) @(posedge clk_i);
        end
        send_code(pick_code(), 1'b0, '{10'sd0, ST_OK});
      end
      stop_sending();
      drain();
    end

    // long hold-off on the receiving side, counted in cycles
    fork
      begin
        recv_hold = 1'b1;
        repeat (300) @(posedge clk_i);
        recv_hold = 1'b0;
      end
      begin
        for (int n = 0; n < 200; n++) send_code(pick_code(), 1'b0, '{10'sd0, ST_OK});
        stop_sending();
      end
    join
    drain();

    if (errors == 0 && pending_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/tac_pkg.sv
rtl/core/tac_udiv.sv
rtl/core/tac_ln.sv
rtl/core/tac_poly.sv
rtl/core/thermistor_adc_to_celsius.sv
rtl/core/tac_checker.sv
test/thermistor_adc_to_celsius_test.sv
